/* src/mtvg_pkg.sv */
// ----------------------------------------------------------------------------
// mtvg_pkg
// Types and constants shared by the MIDI track voice gate modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mtvg_pkg;

    // Track address width in the shared structs (32 tracks at most)
    localparam int TRK_AW = 5;

    // Input actions
    localparam logic [1:0] AC_NOTE_ON  = 2'd0;
    localparam logic [1:0] AC_NOTE_OFF = 2'd1;
    localparam logic [1:0] AC_TICK     = 2'd2;
    localparam logic [1:0] AC_PANIC    = 2'd3;

    // Register indexes (byte address = 8 * index)
    localparam logic [1:0] REG_DUB_ENABLE = 2'd0;
    localparam logic [1:0] REG_PORT_OPEN  = 2'd1;
    localparam logic [1:0] REG_CHAN_LOW   = 2'd2;
    localparam logic [1:0] REG_CHAN_HIGH  = 2'd3;

    // MIDI status high nibbles
    localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
    localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
    localparam logic [3:0] STAT_CONTROL  = 4'hB;

    localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;
    localparam logic [7:0] NOTE_OFFSET      = 8'd11;
    localparam logic [7:0] NOTE_MAX         = 8'd96;
    localparam logic [6:0] VEL_DEFAULT      = 7'd100;
    localparam logic [3:0] LAST_CHANNEL     = 4'd15;

    typedef struct packed {
        logic         dub_enable;
        logic         port_open;
        logic [127:0] chan_map;     // {high map, low map}, track 0 in bits 3:0
    } cfg_t;

    typedef struct packed {
        logic [6:0] note;           // sounding MIDI note, 0 = none
        logic       gate;
    } entry_t;

    typedef struct packed {
        logic              rd_en;
        logic [TRK_AW-1:0] rd_addr;
        logic              wr_en;
        logic [TRK_AW-1:0] wr_addr;
        entry_t            wr_data;
    } mem_req_t;

    typedef struct packed {
        logic [6:0] data_two;
        logic [6:0] data_one;
        logic [7:0] status;
    } msg_t;

endpackage

`default_nettype wire

/* src/mtvg_regs.sv */
// ----------------------------------------------------------------------------
// mtvg_regs
// APB configuration registers: dub enable, port open and the channel maps.
// ----------------------------------------------------------------------------
`default_nettype none

module mtvg_regs
    import mtvg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output cfg_t             cfg
);

    logic        dub_enable_reg;
    logic        port_open_reg;
    logic [63:0] chan_low_reg;
    logic [63:0] chan_high_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign reg_idx = paddr[4:3];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dub_enable_reg <= 1'b1;
            port_open_reg  <= 1'b0;
            chan_low_reg   <= '0;
            chan_high_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_DUB_ENABLE: dub_enable_reg <= pwdata[0];
                REG_PORT_OPEN:  port_open_reg  <= pwdata[0];
                REG_CHAN_LOW:   chan_low_reg   <= pwdata;
                REG_CHAN_HIGH:  chan_high_reg  <= pwdata;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_DUB_ENABLE: prdata = {63'd0, dub_enable_reg};
            REG_PORT_OPEN:  prdata = {63'd0, port_open_reg};
            REG_CHAN_LOW:   prdata = chan_low_reg;
            REG_CHAN_HIGH:  prdata = chan_high_reg;
            default:        prdata = '0;
        endcase
    end

    assign cfg.dub_enable = dub_enable_reg;
    assign cfg.port_open  = port_open_reg;
    assign cfg.chan_map   = {chan_high_reg, chan_low_reg};

endmodule

`default_nettype wire

/* src/mtvg_mem.sv */
// ----------------------------------------------------------------------------
// mtvg_mem
// Per-track voice state memory, one read and one write port, registered
// read data. Per-entry valid bits make every entry read as idle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mtvg_mem
    import mtvg_pkg::*;
#(
    parameter int TRACKS = 32
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mem_req_t req,
    output entry_t        rdata
);

    localparam int AW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

    entry_t            mem [TRACKS];
    logic [TRACKS-1:0] valid_reg;
    entry_t            rd_data_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        if (req.rd_en)
            rd_data_reg <= mem[req.rd_addr[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
                valid_reg[req.wr_addr[AW-1:0]] <= 1'b1;
            if (req.rd_en)
                rd_valid_reg <= valid_reg[req.rd_addr[AW-1:0]];
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

/* src/mtvg_seq.sv */
// ----------------------------------------------------------------------------
// mtvg_seq
// Request sequencer: reads, updates and writes back track entries, builds
// MIDI messages and holds one back so the final one can carry tlast.
// ----------------------------------------------------------------------------
`default_nettype none

module mtvg_seq
    import mtvg_pkg::*;
#(
    parameter int TRACKS = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [1:0] s_action,
    input  wire logic [7:0] s_track,
    input  wire logic [7:0] s_note,
    input  wire logic [7:0] s_velocity,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output msg_t            m_msg,
    output logic            m_tlast,
    output mem_req_t        mem_req,
    input  wire entry_t     mem_rdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_PROC  = 3'd2;
    localparam logic [2:0] ST_CC    = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    localparam logic [TRK_AW-1:0] LAST_TRK = TRK_AW'(TRACKS - 1);

    logic [2:0]        state_reg,    state_next;
    logic [1:0]        act_reg,      act_next;
    logic [TRK_AW-1:0] idx_reg,      idx_next;
    logic [6:0]        note_reg,     note_next;
    logic [6:0]        vel_reg,      vel_next;
    logic              off_done_reg, off_done_next;
    logic [3:0]        cc_reg,       cc_next;
    logic              pend_valid_reg;
    msg_t              pend_msg_reg;
    logic              out_valid_reg;
    msg_t              out_msg_reg;
    logic              out_last_reg;

    logic       accept;
    logic       in_range;
    logic       note_ok;
    logic [7:0] note_sum;
    logic [3:0] chan;
    logic       out_free;
    logic       push_req;
    msg_t       push_msg;
    logic       flush_req;
    logic       step_ok;
    logic       out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign in_range = (s_track < 8'(TRACKS));
    assign note_ok  = (s_note != 8'd0) && (s_note <= NOTE_MAX);
    assign note_sum = s_note + NOTE_OFFSET;
    assign chan     = cfg.chan_map[{idx_reg, 2'b00} +: 4];
    assign out_free = ~out_valid_reg | m_tready;
    assign step_ok  = ~push_req | ~pend_valid_reg | out_free;

    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        idx_next      = idx_reg;
        note_next     = note_reg;
        vel_next      = vel_reg;
        off_done_next = off_done_reg;
        cc_next       = cc_reg;
        push_req      = 1'b0;
        push_msg      = '0;
        flush_req     = 1'b0;
        mem_req       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                act_next      = s_action;
                idx_next      = s_track[TRK_AW-1:0];
                note_next     = note_sum[6:0];
                vel_next      = (s_velocity == 8'd0) ? VEL_DEFAULT : s_velocity[6:0];
                off_done_next = 1'b0;
                cc_next       = '0;
                if (accept)
                begin
                    case (s_action)
                        AC_NOTE_ON:
                            if (cfg.dub_enable && cfg.port_open && in_range && note_ok)
                                state_next = ST_READ;
                        AC_NOTE_OFF:
                            if (cfg.dub_enable && in_range)
                                state_next = ST_READ;
                        AC_TICK:
                        begin
                            idx_next = '0;
                            if (cfg.dub_enable)
                                state_next = ST_READ;
                        end
                        default:
                        begin
                            idx_next   = '0;
                            state_next = ST_READ;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = idx_reg;
                state_next      = ST_PROC;
            end

            ST_PROC:
            begin
                mem_req.wr_addr = idx_reg;
                case (act_reg)
                    AC_NOTE_ON:
                    begin
                        // old note off first, then the new note on
                        if (mem_rdata.note != 7'd0 && !off_done_reg)
                        begin
                            push_req = 1'b1;
                            push_msg = '{data_two: 7'd0, data_one: mem_rdata.note,
                                         status: {STAT_NOTE_OFF, chan}};
                            if (step_ok)
                                off_done_next = 1'b1;
                        end
                        else
                        begin
                            push_req = 1'b1;
                            push_msg = '{data_two: vel_reg, data_one: note_reg,
                                         status: {STAT_NOTE_ON, chan}};
                            if (step_ok)
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_data = '{note: note_reg, gate: 1'b1};
                                state_next      = ST_FLUSH;
                            end
                        end
                    end
                    AC_NOTE_OFF:
                    begin
                        push_req = cfg.port_open && (mem_rdata.note != 7'd0);
                        push_msg = '{data_two: 7'd0, data_one: mem_rdata.note,
                                     status: {STAT_NOTE_OFF, chan}};
                        if (step_ok)
                        begin
                            mem_req.wr_en   = (mem_rdata.note != 7'd0);
                            mem_req.wr_data = '0;
                            state_next      = ST_FLUSH;
                        end
                    end
                    AC_TICK:
                    begin
                        push_req = cfg.port_open && mem_rdata.gate &&
                                   (mem_rdata.note != 7'd0);
                        push_msg = '{data_two: 7'd0, data_one: mem_rdata.note,
                                     status: {STAT_NOTE_OFF, chan}};
                        if (step_ok)
                        begin
                            mem_req.wr_en   = mem_rdata.gate;
                            mem_req.wr_data = '0;
                            idx_next        = idx_reg + 1'b1;
                            state_next      = (idx_reg == LAST_TRK) ? ST_FLUSH : ST_READ;
                        end
                    end
                    default:
                    begin
                        // panic keeps the gate mark
                        push_req = cfg.port_open && (mem_rdata.note != 7'd0);
                        push_msg = '{data_two: 7'd0, data_one: mem_rdata.note,
                                     status: {STAT_NOTE_OFF, chan}};
                        if (step_ok)
                        begin
                            mem_req.wr_en   = (mem_rdata.note != 7'd0);
                            mem_req.wr_data = '{note: 7'd0, gate: mem_rdata.gate};
                            idx_next        = idx_reg + 1'b1;
                            if (idx_reg != LAST_TRK)
                                state_next = ST_READ;
                            else if (cfg.port_open)
                                state_next = ST_CC;
                            else
                                state_next = ST_FLUSH;
                        end
                    end
                endcase
            end

            ST_CC:
            begin
                push_req = 1'b1;
                push_msg = '{data_two: 7'd0, data_one: CC_ALL_NOTES_OFF,
                             status: {STAT_CONTROL, cc_reg}};
                if (step_ok)
                begin
                    cc_next = cc_reg + 1'b1;
                    if (cc_reg == LAST_CHANNEL)
                        state_next = ST_FLUSH;
                end
            end

            ST_FLUSH:
            begin
                flush_req = pend_valid_reg;
                if (!pend_valid_reg || out_free)
                    state_next = ST_IDLE;
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    // held message moves out when a newer one arrives or the request ends
    assign out_load = out_free & ((push_req & pend_valid_reg) | flush_req);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            off_done_reg   <= 1'b0;
            cc_reg         <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            off_done_reg <= off_done_next;
            cc_reg       <= cc_next;
            idx_reg      <= idx_next;

            if (push_req && step_ok)
                pend_valid_reg <= 1'b1;
            else if (flush_req && out_free)
                pend_valid_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        note_reg <= note_next;
        vel_reg  <= vel_next;
        if (push_req && step_ok)
            pend_msg_reg <= push_msg;
        if (out_load)
        begin
            out_msg_reg  <= pend_msg_reg;
            out_last_reg <= flush_req;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_msg    = out_msg_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* src/midi_track_voice_gate_unit.sv */
// ----------------------------------------------------------------------------
// midi_track_voice_gate_unit
// One monophonic MIDI voice per tracker track: note on/off, gate tick and
// panic, emitted as 3-byte MIDI messages.
//
//  Channel  Dir  Beat       Contents
//  s_*      in   request    tuser: action; tdata: track, note, velocity
//  m_*      out  message    tdata: status, data_one, data_two; tlast
//  apb      in   reg write  dub_enable, port_open, channel_map_low/high
//
//  Tick and panic walk every track with one read and one write-back of the
//  track memory per track; panic with the port open then sends controller
//  messages, one a cycle while m_* does not stall.
//  Reset leaves every track idle at once (per-entry valid bits).
//  A stalled m_* holds the sequencer only when a message must move into the output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_track_voice_gate_unit
    import mtvg_pkg::*;
#(
    parameter int TRACKS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // track[7:0], note[15:8], velocity[23:16]
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // status[7:0], data_one[14:8], data_two[21:15]
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    cfg_t     cfg;
    mem_req_t mem_req;
    entry_t   mem_rdata;
    msg_t     m_msg;

    assign pready = 1'b1;

    mtvg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    mtvg_mem #(.TRACKS(TRACKS)) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    mtvg_seq #(.TRACKS(TRACKS)) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_action   (s_tuser),
        .s_track    (s_tdata[7:0]),
        .s_note     (s_tdata[15:8]),
        .s_velocity (s_tdata[23:16]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_msg      (m_msg),
        .m_tlast    (m_tlast),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    assign m_tdata = {2'b00, m_msg.data_two, m_msg.data_one, m_msg.status};

    a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:4] == STAT_NOTE_OFF || m_tdata[7:4] == STAT_NOTE_ON ||
                      m_tdata[7:4] == STAT_CONTROL))
        else $error("unexpected MIDI status kind");

    a_off_ctl_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[7:4] == STAT_NOTE_OFF || m_tdata[7:4] == STAT_CONTROL)
        |-> m_tdata[21:15] == 7'd0)
        else $error("note-off or control message with nonzero second byte");

    a_cc_number: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[7:4] == STAT_CONTROL |-> m_tdata[14:8] == CC_ALL_NOTES_OFF)
        else $error("control message is not all-notes-off");

    a_mem_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.rd_en && mem_req.wr_en |-> mem_req.rd_addr != mem_req.wr_addr)
        else $error("track memory read and write to the same entry");

endmodule

`default_nettype wire
